/* src/dry_cell_face_flux_assert.svh */
// Assertion macros shared by the face flux design.
`ifndef DRY_CELL_FACE_FLUX_ASSERT_SVH
`define DRY_CELL_FACE_FLUX_ASSERT_SVH

// Same-cycle implication.
`define DCFF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcff assertion failed");

// Next-cycle implication.
`define DCFF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcff assertion failed");

`endif

/* src/dcff_pkg.sv */
// Shared types, constants and helpers for the face flux pipeline.
package dcff_pkg;

   localparam int DIM_DEFAULT = 4096;

   // Accept-to-strobe distance in clock edges.
   localparam int PIPE_LAT = 130;

   localparam logic [14:0] C_0296 = 15'd19399;
   localparam logic [14:0] C_0444 = 15'd29098;
   localparam logic [62:0] SAT_CAP = 63'h4000_0000_0000_0000;
   localparam logic [4:0] ALL_DRY = 5'h1F;

   localparam logic [23:0] GRAVITY_RST = 24'd642908;
   localparam logic [15:0] DRY_DEPTH_RST = 16'd66;
   localparam logic [30:0] TIME_STEP_RST = 31'd65536;
   localparam logic [30:0] CELL_SIZE_RST = 31'd131072;

   localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] OUT_MIN = 64'shFFFF_8000_0000_0000;

   typedef enum logic [2:0] {
      REG_GRAVITY,
      REG_DRY_DEPTH,
      REG_TIME_STEP,
      REG_CELL_SIZE,
      REG_ROW_COUNT,
      REG_COL_COUNT
   } reg_index_type;

   typedef struct packed {
      logic               ran;
      logic [62:0]        vol;
      logic signed [63:0] mass;
      logic signed [63:0] mom;
   } face_out_type;

   function automatic logic [47:0] sat48(input logic signed [63:0] v);
      logic [47:0] r;
      if (v > OUT_MAX) begin
         r = OUT_MAX[47:0];
      end else if (v < OUT_MIN) begin
         r = OUT_MIN[47:0];
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

endpackage

/* src/dcff_dly.sv */
// Fixed-length delay line for side data traveling with the pipeline.
module dcff_dly import dcff_pkg::*; #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] tap_ff [N];

   always_ff @(posedge clock) begin
      tap_ff[0] <= d;
      for (int i = 1; i < N; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign q = tap_ff[N-1];

endmodule

/* src/dcff_mul.sv */
// Two-stage unsigned multiplier built from 32x32 partial products.
module dcff_mul import dcff_pkg::*; #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic              clock,
   input  logic [AW-1:0]     a,
   input  logic [BW-1:0]     b,
   output logic [AW+BW-1:0]  p
);

   logic [63:0]      a_w;
   logic [63:0]      b_w;
   logic [63:0]      p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0]     sum;
   logic [AW+BW-1:0] p_ff;

   assign a_w = {{(64-AW){1'b0}}, a};
   assign b_w = {{(64-BW){1'b0}}, b};

   always_ff @(posedge clock) begin
      p00_ff <= a_w[31:0] * b_w[31:0];
      p01_ff <= a_w[31:0] * b_w[63:32];
      p10_ff <= a_w[63:32] * b_w[31:0];
      p11_ff <= a_w[63:32] * b_w[63:32];
   end

   always_comb begin
      sum = {64'h0, p00_ff} + ({64'h0, p01_ff} << 32) + ({64'h0, p10_ff} << 32)
          + {p11_ff, 64'h0};
   end

   always_ff @(posedge clock) begin
      p_ff <= sum[AW+BW-1:0];
   end

   assign p = p_ff;

endmodule

/* src/dcff_sqrt.sv */
// Pipelined floor square root, one result bit per stage.
module dcff_sqrt import dcff_pkg::*; #(
   parameter int IW = 56
) (
   input  logic            clock,
   input  logic [IW-1:0]   rad,
   output logic [IW/2-1:0] root
);

   localparam int ON = IW / 2;
   localparam int RW = ON + 2;

   logic [RW-1:0] rem_q  [ON+1];
   logic [ON-1:0] root_q [ON+1];
   logic [IW-1:0] rad_q  [ON+1];
   logic [RW-1:0] rem_ff  [ON];
   logic [ON-1:0] root_ff [ON];
   logic [IW-1:0] rad_ff  [ON];

   assign rem_q[0]  = '0;
   assign root_q[0] = '0;
   assign rad_q[0]  = rad;

   for (genvar g = 0; g < ON; g++) begin : g_stage
      logic [RW+1:0] acc;
      logic [RW+1:0] trial;
      logic          fit;

      always_comb begin
         acc   = {rem_q[g], rad_q[g][IW-1 -: 2]};
         trial = {{(RW-ON){1'b0}}, root_q[g], 2'b01};
         fit   = acc >= trial;
      end

      always_ff @(posedge clock) begin
         rem_ff[g]  <= fit ? RW'(acc - trial) : acc[RW-1:0];
         root_ff[g] <= {root_q[g][ON-2:0], fit};
         rad_ff[g]  <= {rad_q[g][IW-3:0], 2'b00};
      end

      assign rem_q[g+1]  = rem_ff[g];
      assign root_q[g+1] = root_ff[g];
      assign rad_q[g+1]  = rad_ff[g];
   end

   assign root = root_q[ON];

endmodule

/* src/dcff_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module dcff_div import dcff_pkg::*; #(
   parameter int NW = 63,
   parameter int DW = 31
) (
   input  logic          clock,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo
);

   logic [DW-1:0] rem_q [NW+1];
   logic [NW-1:0] nq_q  [NW+1];
   logic [DW-1:0] den_q [NW+1];
   logic [DW-1:0] rem_ff [NW];
   logic [NW-1:0] nq_ff  [NW];
   logic [DW-1:0] den_ff [NW];

   assign rem_q[0] = '0;
   assign nq_q[0]  = num;
   assign den_q[0] = den;

   for (genvar g = 0; g < NW; g++) begin : g_stage
      logic [DW:0] acc;
      logic        fit;

      always_comb begin
         acc = {rem_q[g], nq_q[g][NW-1]};
         fit = acc >= {1'b0, den_q[g]};
      end

      always_ff @(posedge clock) begin
         rem_ff[g] <= fit ? DW'(acc - {1'b0, den_q[g]}) : acc[DW-1:0];
         nq_ff[g]  <= {nq_q[g][NW-2:0], fit};
         den_ff[g] <= den_q[g];
      end

      assign rem_q[g+1] = rem_ff[g];
      assign nq_q[g+1]  = nq_ff[g];
      assign den_q[g+1] = den_ff[g];
   end

   assign quo = nq_q[NW];

endmodule

/* src/dcff_face.sv */
// One face: hydrostatic or dam-break mass and momentum flux, pipelined.
module dcff_face import dcff_pkg::*; (
   input  logic               clock,
   input  logic               dry,
   input  logic signed [31:0] z_here,
   input  logic signed [31:0] bed_here,
   input  logic signed [31:0] z_nbr,
   input  logic signed [31:0] bed_nbr,
   input  logic [23:0]        gravity,
   input  logic [15:0]        dry_depth,
   input  logic [30:0]        cell_size,
   input  logic [30:0]        time_step,
   output face_out_type       fo
);

   logic signed [31:0] bed_face;
   logic signed [32:0] hf_s, hq_s, dz_s;
   logic [31:0]        hf_in, hq_in, d_in;
   logic               act_in, rit_in;
   logic [31:0]        hf_ff, hq_ff, d_ff;
   logic [1:0]         flg_ff;

   always_comb begin
      bed_face = (bed_nbr > bed_here) ? bed_nbr : bed_here;
      hf_s     = 33'(z_nbr) - 33'(bed_face);
      hq_s     = 33'(z_nbr) - 33'(bed_nbr);
      dz_s     = 33'(z_nbr) - 33'(z_here);
      hf_in    = (hf_s > 0) ? hf_s[31:0] : '0;
      hq_in    = (hq_s > 0) ? hq_s[31:0] : '0;
      rit_in   = dz_s > 0;
      d_in     = (dz_s[31:0] > hf_in) ? hf_in : dz_s[31:0];
      act_in   = !dry && (hf_in > {16'h0, dry_depth});
   end

   always_ff @(posedge clock) begin
      hf_ff  <= hf_in;
      hq_ff  <= hq_in;
      d_ff   <= d_in;
      flg_ff <= {act_in, rit_in};
   end

   // Ritter discharge
   logic [55:0]  gd;
   logic [27:0]  sg;
   logic [31:0]  d_t31;
   logic [59:0]  ds;
   logic [58:0]  qp;
   logic [42:0]  q_t66;

   dcff_mul #(.AW(24), .BW(32)) u_gd (.clock, .a(gravity), .b(d_ff), .p(gd));
   dcff_sqrt #(.IW(56)) u_sg (.clock, .rad(gd), .root(sg));
   dcff_dly #(.W(32), .N(30)) u_d_dly (.clock, .d(d_ff), .q(d_t31));
   dcff_mul #(.AW(32), .BW(28)) u_ds (.clock, .a(d_t31), .b(sg), .p(ds));
   dcff_mul #(.AW(44), .BW(15)) u_q (.clock, .a(ds[59:16]), .b(C_0296), .p(qp));
   dcff_dly #(.W(43), .N(31)) u_q_dly (.clock, .d(qp[58:16]), .q(q_t66));

   // volume rate
   logic [62:0] nv;
   logic [62:0] vol;
   logic [62:0] vol_t127;

   dcff_mul #(.AW(31), .BW(32)) u_nv (.clock, .a(cell_size), .b(hq_ff), .p(nv));
   dcff_div #(.NW(63), .DW(31)) u_vol (.clock, .num(nv), .den(time_step), .quo(vol));
   dcff_dly #(.W(63), .N(61)) u_vol_dly (.clock, .d(vol), .q(vol_t127));

   // Ritter depth and velocity
   logic [46:0] hrp;
   logic [30:0] hr_t66;
   logic [42:0] qc;
   logic [58:0] u_q59;
   logic        hz_t127;
   logic [42:0] qc_t125, qc_t127;
   logic [101:0] mtp;

   dcff_mul #(.AW(32), .BW(15)) u_hr (.clock, .a(d_ff), .b(C_0444), .p(hrp));
   dcff_dly #(.W(31), .N(63)) u_hr_dly (.clock, .d(hrp[46:16]), .q(hr_t66));

   assign qc = ({20'h0, q_t66} > vol) ? vol[42:0] : q_t66;

   dcff_div #(.NW(59), .DW(31)) u_u (.clock, .num({qc, 16'h0}), .den(hr_t66), .quo(u_q59));
   dcff_dly #(.W(1), .N(61)) u_hz_dly (.clock, .d(hr_t66 == '0), .q(hz_t127));
   dcff_dly #(.W(43), .N(59)) u_qc_dly1 (.clock, .d(qc), .q(qc_t125));
   dcff_dly #(.W(43), .N(2)) u_qc_dly2 (.clock, .d(qc_t125), .q(qc_t127));
   dcff_mul #(.AW(43), .BW(59)) u_mt (.clock, .a(qc_t125), .b(u_q59), .p(mtp));

   // pressure terms
   logic [63:0] hh;
   logic [71:0] php;
   logic [54:0] pr_hf_t127;
   logic [61:0] rr;
   logic [69:0] prp;
   logic [52:0] pr_hr_t127;
   logic [1:0]  flg_t127;

   dcff_mul #(.AW(32), .BW(32)) u_hh (.clock, .a(hf_ff), .b(hf_ff), .p(hh));
   dcff_mul #(.AW(48), .BW(24)) u_ph (.clock, .a(hh[63:16]), .b(gravity), .p(php));
   dcff_dly #(.W(55), .N(122)) u_phf_dly (.clock, .d(php[71:17]), .q(pr_hf_t127));
   dcff_mul #(.AW(31), .BW(31)) u_rr (.clock, .a(hrp[46:16]), .b(hrp[46:16]), .p(rr));
   dcff_mul #(.AW(46), .BW(24)) u_pr (.clock, .a(rr[61:16]), .b(gravity), .p(prp));
   dcff_dly #(.W(53), .N(120)) u_phr_dly (.clock, .d(prp[69:17]), .q(pr_hr_t127));
   dcff_dly #(.W(2), .N(126)) u_flg_dly (.clock, .d(flg_ff), .q(flg_t127));

   // combine
   logic [85:0]  mt_sh;
   logic [62:0]  mt, mt_g;
   face_out_type fo_in, fo_ff;

   always_comb begin
      mt_sh    = mtp[101:16];
      mt       = (mt_sh > 86'(SAT_CAP)) ? SAT_CAP : mt_sh[62:0];
      mt_g     = hz_t127 ? '0 : mt;
      fo_in    = '0;
      fo_in.ran = flg_t127[1] && flg_t127[0];
      fo_in.vol = vol_t127;
      if (flg_t127[1]) begin
         if (!flg_t127[0]) begin
            fo_in.mom = 64'(pr_hf_t127);
         end else begin
            fo_in.mass = -(64'(qc_t127));
            fo_in.mom  = 64'(mt_g) + 64'(pr_hr_t127);
         end
      end
   end

   always_ff @(posedge clock) begin
      fo_ff <= fo_in;
   end

   assign fo = fo_ff;

endmodule

/* src/dcff_weir.sv */
// Weir discharge of the cell depth, pipelined.
module dcff_weir import dcff_pkg::*; (
   input  logic               clock,
   input  logic signed [31:0] z_here,
   input  logic signed [31:0] bed_here,
   input  logic [23:0]        gravity,
   output logic [43:0]        weir
);

   logic signed [32:0] hp_s;
   logic [31:0]        hp_in, hp_ff, hp_t25;
   logic [23:0]        sh;
   logic [19:0]        sgv;
   logic [55:0]        wp;
   logic [59:0]        qp;

   always_comb begin
      hp_s  = 33'(z_here) - 33'(bed_here);
      hp_in = (hp_s > 0) ? hp_s[31:0] : '0;
   end

   always_ff @(posedge clock) begin
      hp_ff <= hp_in;
   end

   dcff_sqrt #(.IW(48)) u_sh (.clock, .rad({hp_ff, 16'h0}), .root(sh));
   dcff_dly #(.W(32), .N(24)) u_hp_dly (.clock, .d(hp_ff), .q(hp_t25));
   dcff_mul #(.AW(32), .BW(24)) u_w (.clock, .a(hp_t25), .b(sh), .p(wp));
   // the user must hold gravity static while cells are in flight; the block does not enforce it
   dcff_sqrt #(.IW(40)) u_sg (.clock, .rad({gravity, 16'h0}), .root(sgv));
   dcff_mul #(.AW(20), .BW(40)) u_q (.clock, .a(sgv), .b(wp[55:16]), .p(qp));

   assign weir = qp[59:16];

endmodule

/* src/dry_cell_face_flux.sv */
// Top level: wet/dry face flux pipeline with APB register port.
// Takes one cell per clock; busy is always low. Each cell's result is driven on
// the rsp_ ports for one cycle, marked by rsp_strobe; results come out in cell
// order, and the receiver cannot stall. The depth is set by the chained pipelined
// dividers of each face (63-stage volume rate, then 59-stage velocity), the
// two-stage multipliers ahead of and behind them, and the input, face output
// and result registers. Write registers only while no cell is in flight.
`include "dry_cell_face_flux_assert.svh"

module dry_cell_face_flux import dcff_pkg::*; #(
   parameter int MAX_DIM = DIM_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [4:0]         req_dry_flags,
   input  logic signed [31:0] req_bed_here,
   input  logic signed [31:0] req_bed_east,
   input  logic signed [31:0] req_bed_north,
   input  logic signed [31:0] req_level_here,
   input  logic signed [31:0] req_level_east,
   input  logic signed [31:0] req_level_north,
   input  logic [12:0]        req_row_index,
   input  logic [12:0]        req_col_index,
   output logic               rsp_strobe,
   output logic               rsp_clear_cell,
   output logic signed [47:0] rsp_north_mass_flux,
   output logic signed [47:0] rsp_north_xmom_flux,
   output logic signed [47:0] rsp_north_ymom_flux,
   output logic signed [47:0] rsp_east_mass_flux,
   output logic signed [47:0] rsp_east_xmom_flux,
   output logic signed [47:0] rsp_east_ymom_flux,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam logic [12:0] DIM_RST = 13'(MAX_DIM % 8192);

   // registers
   logic [23:0]   gravity_ff;
   logic [15:0]   dry_depth_ff;
   logic [30:0]   time_step_ff, cell_size_ff, dt;
   logic [12:0]   row_count_ff, col_count_ff;
   logic          csr_wr;
   reg_index_type csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff   <= GRAVITY_RST;
         dry_depth_ff <= DRY_DEPTH_RST;
         time_step_ff <= TIME_STEP_RST;
         cell_size_ff <= CELL_SIZE_RST;
         row_count_ff <= DIM_RST;
         col_count_ff <= DIM_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_GRAVITY:   gravity_ff   <= pwdata[23:0];
            REG_DRY_DEPTH: dry_depth_ff <= pwdata[15:0];
            REG_TIME_STEP: time_step_ff <= pwdata[30:0];
            REG_CELL_SIZE: cell_size_ff <= pwdata[30:0];
            REG_ROW_COUNT: row_count_ff <= pwdata[12:0];
            REG_COL_COUNT: col_count_ff <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_GRAVITY:   prdata = 32'(gravity_ff);
         REG_DRY_DEPTH: prdata = 32'(dry_depth_ff);
         REG_TIME_STEP: prdata = 32'(time_step_ff);
         REG_CELL_SIZE: prdata = 32'(cell_size_ff);
         REG_ROW_COUNT: prdata = 32'(row_count_ff);
         REG_COL_COUNT: prdata = 32'(col_count_ff);
         default:       prdata = '0;
      endcase
   end

   assign dt = (time_step_ff == '0) ? 31'd1 : time_step_ff;

   // input stage and valid chain
   logic                accept;
   logic [PIPE_LAT-1:0] vld_ff, vld_in;
   logic [4:0]          flags_ff;
   logic signed [31:0]  bh_ff, be_ff, bn_ff, zh_ff, ze_ff, zn_ff;
   logic [12:0]         row_ff, col_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[PIPE_LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= req_dry_flags;
      bh_ff    <= req_bed_here;
      be_ff    <= req_bed_east;
      bn_ff    <= req_bed_north;
      zh_ff    <= req_level_here;
      ze_ff    <= req_level_east;
      zn_ff    <= req_level_north;
      row_ff   <= req_row_index;
      col_ff   <= req_col_index;
   end

   // faces and weir
   face_out_type fo_east, fo_north;
   logic [43:0]  weir_t29, weir_t128;
   logic [2:0]   sel_in, sel_t128;

   dcff_face u_east (
      .clock, .dry(flags_ff[2]), .z_here(zh_ff), .bed_here(bh_ff),
      .z_nbr(ze_ff), .bed_nbr(be_ff), .gravity(gravity_ff), .dry_depth(dry_depth_ff),
      .cell_size(cell_size_ff), .time_step(dt), .fo(fo_east)
   );

   dcff_face u_north (
      .clock, .dry(flags_ff[4]), .z_here(zh_ff), .bed_here(bh_ff),
      .z_nbr(zn_ff), .bed_nbr(bn_ff), .gravity(gravity_ff), .dry_depth(dry_depth_ff),
      .cell_size(cell_size_ff), .time_step(dt), .fo(fo_north)
   );

   dcff_weir u_weir (
      .clock, .z_here(zh_ff), .bed_here(bh_ff), .gravity(gravity_ff), .weir(weir_t29)
   );

   dcff_dly #(.W(44), .N(99)) u_weir_dly (.clock, .d(weir_t29), .q(weir_t128));

   assign sel_in = {flags_ff == ALL_DRY,
                    col_ff == 13'd1 || col_ff == col_count_ff,
                    row_ff == 13'd1 || row_ff == row_count_ff};

   dcff_dly #(.W(3), .N(128)) u_sel_dly (.clock, .d(sel_in), .q(sel_t128));

   // result stage
   logic [62:0]        vsel;
   logic [43:0]        wq;
   logic signed [63:0] fn1, fe1;
   logic               clear_in, clear_ff;
   logic [47:0]        nm_in, ny_in, em_in, ex_in;
   logic [47:0]        nm_ff, ny_ff, em_ff, ex_ff;

   always_comb begin
      if (fo_north.ran) begin
         vsel = fo_north.vol;
      end else if (fo_east.ran) begin
         vsel = fo_east.vol;
      end else begin
         vsel = '0;
      end
      wq  = ({19'h0, weir_t128} < vsel) ? weir_t128 : vsel[43:0];
      fn1 = sel_t128[1] ? 64'(wq) : fo_north.mass;
      fe1 = sel_t128[0] ? 64'(wq) : fo_east.mass;
      clear_in = sel_t128[2];
      if (sel_t128[2]) begin
         nm_in = '0;
         ny_in = '0;
         em_in = '0;
         ex_in = '0;
      end else begin
         nm_in = sat48(fn1);
         ny_in = sat48(fo_north.mom);
         em_in = sat48(fe1);
         ex_in = sat48(fo_east.mom);
      end
   end

   always_ff @(posedge clock) begin
      clear_ff <= clear_in;
      nm_ff    <= nm_in;
      ny_ff    <= ny_in;
      em_ff    <= em_in;
      ex_ff    <= ex_in;
   end

   assign rsp_strobe          = vld_ff[PIPE_LAT-1];
   assign rsp_clear_cell      = clear_ff;
   assign rsp_north_mass_flux = nm_ff;
   assign rsp_north_xmom_flux = '0;
   assign rsp_north_ymom_flux = ny_ff;
   assign rsp_east_mass_flux  = em_ff;
   assign rsp_east_xmom_flux  = ex_ff;
   assign rsp_east_ymom_flux  = '0;

   `DCFF_ASSERT_IMP(a_strobe_lat, clock, reset, rsp_strobe, $past(accept, PIPE_LAT))
   `DCFF_ASSERT_IMP(a_clear_zero, clock, reset, rsp_strobe && rsp_clear_cell, rsp_north_mass_flux == 0 && rsp_east_mass_flux == 0 && rsp_east_xmom_flux == 0)
   `DCFF_ASSERT_NXT(a_tstep_wr, clock, reset, csr_wr && csr_idx == REG_TIME_STEP, time_step_ff == $past(pwdata[30:0]))

endmodule

/* verif/tb_dry_cell_face_flux.sv */
// Self-checking testbench for the wet/dry face flux block: directed and random cells.
module tb_dry_cell_face_flux;
   import dcff_pkg::*;

   typedef struct packed {
      logic [4:0]         flags;
      logic signed [31:0] bed_here;
      logic signed [31:0] bed_east;
      logic signed [31:0] bed_north;
      logic signed [31:0] lvl_here;
      logic signed [31:0] lvl_east;
      logic signed [31:0] lvl_north;
      logic [12:0]        row;
      logic [12:0]        col;
   } cell_type;

   typedef struct packed {
      logic        clear;
      logic [47:0] n_mass;
      logic [47:0] n_xmom;
      logic [47:0] n_ymom;
      logic [47:0] e_mass;
      logic [47:0] e_xmom;
      logic [47:0] e_ymom;
   } flux_type;

   localparam logic [63:0] CAP = 64'h4000_0000_0000_0000;
   localparam int WATCHDOG_LIMIT = 6000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [4:0] req_dry_flags = '0;
   logic signed [31:0] req_bed_here = '0, req_bed_east = '0, req_bed_north = '0;
   logic signed [31:0] req_level_here = '0, req_level_east = '0, req_level_north = '0;
   logic [12:0] req_row_index = 13'd1, req_col_index = 13'd1;
   logic rsp_strobe, rsp_clear_cell;
   logic signed [47:0] rsp_north_mass_flux, rsp_north_xmom_flux, rsp_north_ymom_flux;
   logic signed [47:0] rsp_east_mass_flux, rsp_east_xmom_flux, rsp_east_ymom_flux;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // register shadow
   logic [63:0] grav_r, dry_r, dt_r, dxy_r, rows_r, cols_r;

   flux_type flux_q[$];
   int errors = 0;
   int idle_pct = 0;
   int quiet_cycles = 0;

   dry_cell_face_flux dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_dry_flags(req_dry_flags), .req_bed_here(req_bed_here),
      .req_bed_east(req_bed_east), .req_bed_north(req_bed_north),
      .req_level_here(req_level_here), .req_level_east(req_level_east),
      .req_level_north(req_level_north), .req_row_index(req_row_index),
      .req_col_index(req_col_index), .rsp_strobe(rsp_strobe),
      .rsp_clear_cell(rsp_clear_cell), .rsp_north_mass_flux(rsp_north_mass_flux),
      .rsp_north_xmom_flux(rsp_north_xmom_flux),
      .rsp_north_ymom_flux(rsp_north_ymom_flux),
      .rsp_east_mass_flux(rsp_east_mass_flux), .rsp_east_xmom_flux(rsp_east_xmom_flux),
      .rsp_east_ymom_flux(rsp_east_ymom_flux), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // floor(a*b >> s), saturated
   function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b,
                                           input int s);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> s;
      return (p > {64'd0, CAP}) ? CAP : p[63:0];
   endfunction

   function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
      logic [63:0] r, bit_v;
      r = '0;
      bit_v = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (v >= r + bit_v) begin
            v = v - (r + bit_v);
            r = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] water_depth(input logic signed [63:0] lvl,
                                               input logic signed [63:0] bed);
      logic signed [63:0] d;
      d = lvl - bed;
      return (d > 0) ? d : 64'd0;
   endfunction

   function automatic logic [63:0] hydro_pressure(input logic [63:0] h);
      return mul_sat(mul_sat(h, h, 16), grav_r, 17);
   endfunction

   function automatic logic [47:0] clamp48(input logic signed [63:0] v);
      if (v > OUT_MAX) return OUT_MAX[47:0];
      if (v < OUT_MIN) return OUT_MIN[47:0];
      return v[47:0];
   endfunction

   function automatic void face_flux(input logic signed [63:0] zp, input logic signed [63:0] zbp,
                                     input logic signed [63:0] zq, input logic signed [63:0] zbq,
                                     output logic [63:0] mass, output logic [63:0] mom,
                                     inout logic [63:0] vol);
      logic signed [63:0] zbf;
      logic [63:0] hf, hq, dt, d, s, q, hr, u, mt, pr;
      zbf = (zbq > zbp) ? zbq : zbp;
      hf = water_depth(zq, zbf);
      hq = water_depth(zq, zbq);
      dt = (dt_r != 0) ? dt_r : 64'd1;
      mass = '0;
      mom = '0;
      if (hf <= dry_r) return;
      if (zq <= zp) begin
         mom = hydro_pressure(hf);
         return;
      end
      d = zq - zp;
      if (d > hf) d = hf;
      s = sqrt_floor(grav_r * d);
      q = mul_sat(mul_sat(d, s, 16), 64'(C_0296), 16);
      hr = (64'(C_0444) * d) >> 16;
      vol = (dxy_r * hq) / dt;
      if (q > vol) q = vol;
      u = (hr != 0) ? ((q << 16) / hr) : 64'd0;
      mt = (hr != 0) ? mul_sat(q, u, 16) : 64'd0;
      pr = hydro_pressure(hr);
      mass = -q;
      mom = mt + pr;
   endfunction

   function automatic flux_type predict_flux(input cell_type c);
      flux_type f;
      logic [63:0] fe1, fe2, fn1, fn3, vol, hp, w, weir, wq;
      logic signed [63:0] zp, zbp;
      f = '0;
      fe1 = '0; fe2 = '0; fn1 = '0; fn3 = '0; vol = '0;
      zp = c.lvl_here;
      zbp = c.bed_here;
      if (c.flags == ALL_DRY) begin
         f.clear = 1'b1;
         return f;
      end
      if (!c.flags[2]) face_flux(zp, zbp, c.lvl_east, c.bed_east, fe1, fe2, vol);
      if (!c.flags[4]) face_flux(zp, zbp, c.lvl_north, c.bed_north, fn1, fn3, vol);
      if (c.col == 1 || c.col == cols_r[12:0] || c.row == 1 || c.row == rows_r[12:0]) begin
         hp = water_depth(zp, zbp);
         w = mul_sat(hp, sqrt_floor(hp << 16), 16);
         weir = mul_sat(sqrt_floor(grav_r << 16), w, 16);
         wq = (weir < vol) ? weir : vol;
         if (c.col == 1 || c.col == cols_r[12:0]) fn1 = wq;
         if (c.row == 1 || c.row == rows_r[12:0]) fe1 = wq;
      end
      f.n_mass = clamp48(fn1);
      f.n_ymom = clamp48(fn3);
      f.e_mass = clamp48(fe1);
      f.e_xmom = clamp48(fe2);
      return f;
   endfunction

   task automatic send_cell(input cell_type c);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_dry_flags <= c.flags;
      req_bed_here <= c.bed_here;
      req_bed_east <= c.bed_east;
      req_bed_north <= c.bed_north;
      req_level_here <= c.lvl_here;
      req_level_east <= c.lvl_east;
      req_level_north <= c.lvl_north;
      req_row_index <= c.row;
      req_col_index <= c.col;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      flux_q.push_back(predict_flux(c));
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (flux_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_GRAVITY:   grav_r = v[23:0];
         REG_DRY_DEPTH: dry_r = v[15:0];
         REG_TIME_STEP: dt_r = v[30:0];
         REG_CELL_SIZE: dxy_r = v[30:0];
         REG_ROW_COUNT: rows_r = v[12:0];
         REG_COL_COUNT: cols_r = v[12:0];
         default: ;
      endcase
   endtask

   function automatic logic [12:0] pick_index(input logic [63:0] last);
      int r;
      r = $urandom_range(9);
      if (r == 0) return 13'd1;
      if (r == 1) return last[12:0];
      if (r == 2) return 13'd4096;
      return 13'($urandom_range(4096, 1));
   endfunction

   function automatic logic signed [31:0] near(input logic signed [31:0] base, input int span);
      return base + $signed($urandom_range(2 * span)) - span;
   endfunction

   // mostly physical cells with random content; some raw noise
   function automatic cell_type random_cell();
      cell_type c;
      int m;
      m = $urandom_range(9);
      if (m == 0) begin
         c.bed_here = $urandom; c.bed_east = $urandom; c.bed_north = $urandom;
         c.lvl_here = $urandom; c.lvl_east = $urandom; c.lvl_north = $urandom;
      end else begin
         c.bed_here = $signed($urandom_range(40 << 16)) - (20 << 16);
         c.bed_east = near(c.bed_here, 1 << 16);
         c.bed_north = near(c.bed_here, 1 << 16);
         c.lvl_here = c.bed_here + $signed($urandom_range(m < 3 ? 200 : (4 << 16)));
         c.lvl_east = near(c.lvl_here, (m < 5) ? 300 : (2 << 16));
         c.lvl_north = near(c.lvl_here, (m < 5) ? 300 : (2 << 16));
      end
      c.flags = ($urandom_range(9) == 0) ? ALL_DRY : 5'($urandom);
      if ($urandom_range(2) == 0) c.flags = c.flags & 5'b01010;
      c.row = pick_index(rows_r);
      c.col = pick_index(cols_r);
      return c;
   endfunction

   function automatic cell_type flat_cell(input logic signed [31:0] bed,
                                          input logic signed [31:0] here,
                                          input logic signed [31:0] east,
                                          input logic signed [31:0] north);
      cell_type c;
      c.flags = 5'b00000;
      c.bed_here = bed; c.bed_east = bed; c.bed_north = bed;
      c.lvl_here = here; c.lvl_east = east; c.lvl_north = north;
      c.row = 13'd100;
      c.col = 13'd100;
      return c;
   endfunction

   task automatic test_directed;
      cell_type c;
      idle_pct = 11;
      c = flat_cell(0, 2 << 16, 2 << 16, 2 << 16);
      c.flags = ALL_DRY;
      send_cell(c);
      send_cell(flat_cell(0, 2 << 16, 1 << 16, 1 << 16));    // hydrostatic both faces
      send_cell(flat_cell(0, 1 << 16, 3 << 16, 1 << 16));    // east dam break
      send_cell(flat_cell(0, 1 << 16, 1 << 16, 3 << 16));    // north dam break
      send_cell(flat_cell(0, 1 << 16, (1 << 16) + 1, 40));     // tiny step, shallow face
      send_cell(flat_cell(0, 1 << 16, (1 << 16) + 2, 1 << 16)); // Ritter depth truncates
      c = flat_cell(0, 1 << 16, 3 << 16, 2 << 16);
      c.flags = 5'b10101;                                    // dry neighbours
      send_cell(c);
      c = flat_cell(0, 2 << 16, 3 << 16, 1 << 16);
      c.col = 13'd1;
      send_cell(c);
      c.col = cols_r[12:0];
      send_cell(c);
      c.col = 13'd50;
      c.row = 13'd1;
      send_cell(c);
      c.row = rows_r[12:0];
      c.col = 13'd1;
      send_cell(c);
      c = flat_cell(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
      c.row = 13'd4096;
      c.col = 13'd4096;
      send_cell(c);
      c = flat_cell(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      c.bed_east = 32'sh8000_0000;
      c.bed_north = 32'sh8000_0000;
      c.flags = 5'b01011;
      send_cell(c);
      c = flat_cell(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      c.row = 13'd1;
      c.col = 13'd1;
      send_cell(c);
   endtask

   task automatic test_random_cells(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 3) idle_pct = 85;
         if (i == 2 * count / 3) idle_pct = 0;
         if (i == count / 2) drain;
         send_cell(random_cell());
      end
   endtask

   task automatic apply_settings(input logic [31:0] g, input logic [31:0] dd,
                                 input logic [31:0] dt, input logic [31:0] dx,
                                 input logic [31:0] rc, input logic [31:0] cc);
      drain;
      csr_write(REG_GRAVITY, g);
      csr_write(REG_DRY_DEPTH, dd);
      csr_write(REG_TIME_STEP, dt);
      csr_write(REG_CELL_SIZE, dx);
      csr_write(REG_ROW_COUNT, rc);
      csr_write(REG_COL_COUNT, cc);
   endtask

   task automatic test_register_sweep;
      apply_settings(1, 0, 1, 1, 1, 1);
      test_random_cells(60);
      apply_settings(24'hFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 4096, 4096);
      test_random_cells(60);
      apply_settings(24'hFF_FFFF, 0, 1, 31'h7FFF_FFFF, 7, 9);
      test_random_cells(60);
      apply_settings(9 << 16, 300, 1 << 12, 1 << 20, 2, 4095);
      test_random_cells(60);
      apply_settings(1, 16'hFFFF, 31'h7FFF_FFFF, 1, 4096, 1);
      test_random_cells(60);
      apply_settings(GRAVITY_RST, DRY_DEPTH_RST, TIME_STEP_RST, CELL_SIZE_RST, 33, 17);
      test_random_cells(60);
   endtask

   always @(posedge clock) begin
      flux_type e;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("dry_cell_face_flux test failed");
            $finish;
         end
         if (rsp_strobe) begin
            if (flux_q.size() == 0) begin
               $error("unexpected transfer on rsp_strobe");
               errors++;
            end else begin
               e = flux_q.pop_front();
               if (rsp_clear_cell !== e.clear) begin
                  $error("clear_cell exp %0h got %0h", e.clear, rsp_clear_cell); errors++;
               end
               if (rsp_north_mass_flux !== e.n_mass) begin
                  $error("north_mass_flux exp %0h got %0h", e.n_mass, rsp_north_mass_flux);
                  errors++;
               end
               if (rsp_north_xmom_flux !== e.n_xmom) begin
                  $error("north_xmom_flux exp %0h got %0h", e.n_xmom, rsp_north_xmom_flux);
                  errors++;
               end
               if (rsp_north_ymom_flux !== e.n_ymom) begin
                  $error("north_ymom_flux exp %0h got %0h", e.n_ymom, rsp_north_ymom_flux);
                  errors++;
               end
               if (rsp_east_mass_flux !== e.e_mass) begin
                  $error("east_mass_flux exp %0h got %0h", e.e_mass, rsp_east_mass_flux);
                  errors++;
               end
               if (rsp_east_xmom_flux !== e.e_xmom) begin
                  $error("east_xmom_flux exp %0h got %0h", e.e_xmom, rsp_east_xmom_flux);
                  errors++;
               end
               if (rsp_east_ymom_flux !== e.e_ymom) begin
                  $error("east_ymom_flux exp %0h got %0h", e.e_ymom, rsp_east_ymom_flux);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      grav_r = GRAVITY_RST;
      dry_r = DRY_DEPTH_RST;
      dt_r = TIME_STEP_RST;
      dxy_r = CELL_SIZE_RST;
      rows_r = DIM_DEFAULT & 13'h1FFF;
      cols_r = DIM_DEFAULT & 13'h1FFF;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed;
      test_random_cells(330);
      test_register_sweep;
      drain;
      repeat (PIPE_LAT + 10) @(posedge clock);
      if (errors == 0) begin
         $display("dry_cell_face_flux test passed");
      end else begin
         $display("dry_cell_face_flux test failed");
      end
      $finish;
   end

endmodule
